FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define KES_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define KES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: hdl/kes_pkg.sv
// ----------------------------------------------------------------------------
// kes_pkg
// Shared types and constants of the keypad event scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kes_pkg;

	// Matrix size and field widths
	localparam int NUM_BUTTONS = 20;
	localparam int IN_W        = 20;
	localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int BTN_W       = 5;
	localparam int CNT_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	// Register reset values
	localparam logic [CNT_W-1:0] HOLD_START_RST  = CNT_W'(2);
	localparam logic [CNT_W-1:0] HOLD_REPEAT_RST = CNT_W'(1);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLD_START  = 2'd0,
		REG_HOLD_REPEAT = 2'd1
	} reg_idx_t;

	// Event codes
	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_DOWN = 2'd1,
		ACT_HOLD = 2'd2,
		ACT_UP   = 2'd3
	} act_t;

	// Configuration register file contents
	typedef struct packed {
		logic [CNT_W-1:0] hold_start;
		logic [CNT_W-1:0] hold_repeat;
	} kes_cfg_t;

	// One tick's result
	typedef struct packed {
		logic             event_valid;
		logic [BTN_W-1:0] button;
		act_t             action;
	} kes_result_t;

endpackage

FILE: hdl/kes_cfg.sv
// ----------------------------------------------------------------------------
// kes_cfg
// Configuration registers: hold start and hold repeat intervals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kes_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kes_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kes_pkg::CFG_DATA_W-1:0]   cfg_data,
	output kes_pkg::kes_cfg_t                cfg
);

	kes_pkg::kes_cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_start  <= kes_pkg::HOLD_START_RST;
			cfg_q.hold_repeat <= kes_pkg::HOLD_REPEAT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kes_pkg::REG_HOLD_START:  cfg_q.hold_start  <= cfg_data[kes_pkg::CNT_W-1:0];
				kes_pkg::REG_HOLD_REPEAT: cfg_q.hold_repeat <= cfg_data[kes_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/kes_scan.sv
// ----------------------------------------------------------------------------
// kes_scan
// One scan tick: first active button, event decode and next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kes_scan (
	input  logic [kes_pkg::IN_W-1:0]         mask,
	input  logic [kes_pkg::NUM_BUTTONS-1:0]  key_down,
	input  logic [kes_pkg::CNT_W-1:0]        hold_count,
	input  logic [kes_pkg::CNT_W-1:0]        repeat_count,
	input  kes_pkg::kes_cfg_t                cfg,
	output logic [kes_pkg::NUM_BUTTONS-1:0]  key_down_next,
	output logic [kes_pkg::CNT_W-1:0]        hold_next,
	output logic [kes_pkg::CNT_W-1:0]        repeat_next,
	output kes_pkg::kes_result_t             result
);

	localparam int NB = kes_pkg::NUM_BUTTONS;

	logic [NB+kes_pkg::IN_W-1:0]  mask_ext;
	logic [NB-1:0]                closed;
	logic [NB-1:0]                active;
	logic                         hit;
	logic [kes_pkg::IDX_W-1:0]    hit_idx;
	logic [kes_pkg::BTN_W-1:0]    hit_btn;

	// Buttons past the input width read as released
	assign mask_ext = {{NB{1'b0}}, mask};
	assign closed   = mask_ext[NB-1:0];
	assign active   = closed | key_down;

	// Lowest-index button that is pressed now or was pressed before
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		hit_btn = '0;
		for (int i = NB - 1; i >= 0; i--) begin
			if (active[i]) begin
				hit     = 1'b1;
				hit_idx = kes_pkg::IDX_W'(i);
				hit_btn = kes_pkg::BTN_W'(i);
			end
		end
	end

	// Event decode and state update for the selected button
	always_comb begin
		key_down_next      = key_down;
		hold_next          = hold_count;
		repeat_next        = repeat_count;
		result.event_valid = 1'b0;
		result.button      = '0;
		result.action      = kes_pkg::ACT_NONE;
		if (hit) begin
			if (closed[hit_idx] && !key_down[hit_idx]) begin
				// new press
				key_down_next[hit_idx] = 1'b1;
				result.event_valid     = 1'b1;
				result.button          = hit_btn;
				result.action          = kes_pkg::ACT_DOWN;
			end else if (closed[hit_idx]) begin
				// still held: count up to start, then repeat
				if (hold_count >= cfg.hold_start) begin
					hold_next = cfg.hold_start;
					if (repeat_count >= cfg.hold_repeat) begin
						repeat_next        = '0;
						result.event_valid = 1'b1;
						result.button      = hit_btn;
						result.action      = kes_pkg::ACT_HOLD;
					end else begin
						repeat_next = repeat_count + 1'b1;
					end
				end else begin
					hold_next = hold_count + 1'b1;
				end
			end else begin
				// release
				key_down_next[hit_idx] = 1'b0;
				hold_next              = '0;
				repeat_next            = '0;
				result.event_valid     = 1'b1;
				result.button          = hit_btn;
				result.action          = kes_pkg::ACT_UP;
			end
		end
	end

endmodule

FILE: hdl/keypad_event_scanner_top.sv
// ----------------------------------------------------------------------------
// keypad_event_scanner_top
// Matrix keypad scanner with auto-repeat, one result per scan tick.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------
//  in      | in_valid  | in_stall  | pressed_mask
//  out     | out_valid | out_stall | event_valid, button, action
//  cfg     | cfg_we    | -         | cfg_index, cfg_data
//
//  One tick per cycle unless out_stall holds a full pipe; a tick passes mask_s1, then result_q.
//  Scan, decode and counter update are combinational logic after the input register.
//  Reset releases every key, clears both counters and loads the default intervals.
//  A stalled output holds its result; in_stall rises only when both stages are full
//  and out_stall is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_event_scanner_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [kes_pkg::IN_W-1:0]         pressed_mask,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             event_valid,
	output logic [kes_pkg::BTN_W-1:0]        button,
	output logic [1:0]                       action,
	input  logic                             cfg_we,
	input  logic [kes_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kes_pkg::CFG_DATA_W-1:0]   cfg_data
);

	kes_pkg::kes_cfg_t                cfg;
	logic                             valid_s1;
	logic [kes_pkg::IN_W-1:0]         mask_s1;
	logic                             out_valid_q;
	kes_pkg::kes_result_t             result_q;
	kes_pkg::kes_result_t             result_d;
	logic [kes_pkg::NUM_BUTTONS-1:0]  key_down_q;
	logic [kes_pkg::NUM_BUTTONS-1:0]  key_down_d;
	logic [kes_pkg::CNT_W-1:0]        hold_q;
	logic [kes_pkg::CNT_W-1:0]        hold_d;
	logic [kes_pkg::CNT_W-1:0]        repeat_q;
	logic [kes_pkg::CNT_W-1:0]        repeat_d;
	logic                             advance;

	kes_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kes_scan u_scan (
		.mask          (mask_s1),
		.key_down      (key_down_q),
		.hold_count    (hold_q),
		.repeat_count  (repeat_q),
		.cfg           (cfg),
		.key_down_next (key_down_d),
		.hold_next     (hold_d),
		.repeat_next   (repeat_d),
		.result        (result_d)
	);

	// Stage 1 moves into the result register when that slot is free or drains
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Control and key state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			key_down_q  <= '0;
			hold_q      <= '0;
			repeat_q    <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				key_down_q  <= key_down_d;
				hold_q      <= hold_d;
				repeat_q    <= repeat_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mask_s1 <= pressed_mask;
		end
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_valid = result_q.event_valid;
	assign button      = result_q.button;
	assign action      = result_q.action;

endmodule

FILE: hdl/kes_checker.sv
// ----------------------------------------------------------------------------
// kes_checker
// Port-level checks on the keypad event scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kes_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [kes_pkg::IN_W-1:0]         pressed_mask,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             event_valid,
	input  logic [kes_pkg::BTN_W-1:0]        button,
	input  logic [1:0]                       action
);

	logic                       in_held;
	logic                       out_held;
	logic [kes_pkg::BTN_W+2:0]  res_bits;
	logic                       res_quiet;

	assign in_held   = in_valid && in_stall;
	assign out_held  = out_valid && out_stall;
	assign res_bits  = {event_valid, button, action};
	assign res_quiet = (button == '0) && (action == kes_pkg::ACT_NONE);

	// A stalled tick stays put until its transfer
	`KES_ASSERT_NEXT(a_in_hold, clk, arst_n, in_held, in_valid && $stable(pressed_mask))

	// A stalled result stays put until its transfer
	`KES_ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, out_valid && $stable(res_bits))

	// A quiet tick reports zero button and no action
	`KES_ASSERT_IMPLY(a_quiet_zero, clk, arst_n, out_valid && !event_valid, res_quiet)

	// A reported event never has both a zero button and no action
	`KES_ASSERT_IMPLY(a_event_act, clk, arst_n, out_valid && event_valid, !res_quiet || button != '0)

	// Input backs up only behind a stalled result
	`KES_ASSERT_IMPLY(a_stall_cause, clk, arst_n, in_stall, out_held)

endmodule

bind keypad_event_scanner_top kes_checker u_kes_checker (.*);

FILE: sim/tb_keypad_event_scanner_top.sv
// ----------------------------------------------------------------------------
// tb_keypad_event_scanner_top
// Self-checking bench for the keypad event scanner. A directed table covers
// reset, the extreme masks and intervals, the hold-counter clamp and ignored
// register writes. Four phases of keypad-like random traffic follow, under
// changing sender idling and receiver stalls. Every transfer is predicted
// in-bench and the results are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keypad_event_scanner_top;

	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_TICKS  = 125;

	// Register indexes that lie beyond the register list
	localparam logic [kes_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [kes_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam kes_pkg::kes_result_t NO_EVENT = '{1'b0, 5'd0, kes_pkg::ACT_NONE};

	// Directed table: a scan tick or a register write per row
	typedef enum bit {ROW_TICK, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [kes_pkg::CFG_IDX_W-1:0]   reg_sel;
		logic [kes_pkg::CFG_DATA_W-1:0]  reg_val;
		logic [kes_pkg::IN_W-1:0]        mask;
		bit                              typed;
		kes_pkg::kes_result_t            res;
	} row_t;

	localparam int NUM_ROWS = 36;

	row_t dir_rows [NUM_ROWS] = '{
		'{ROW_TICK, 2'd0, 8'd0, 20'h00000, 1'b1, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00001, 1'b1, '{1'b1, 5'd0,  kes_pkg::ACT_DOWN}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00001, 1'b0, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00001, 1'b0, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00001, 1'b0, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00001, 1'b0, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00001, 1'b0, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00001, 1'b0, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00000, 1'b1, '{1'b1, 5'd0,  kes_pkg::ACT_UP}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h80000, 1'b1, '{1'b1, 5'd19, kes_pkg::ACT_DOWN}},
		'{ROW_TICK, 2'd0, 8'd0, 20'hFFFFF, 1'b1, '{1'b1, 5'd0,  kes_pkg::ACT_DOWN}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00000, 1'b1, '{1'b1, 5'd0,  kes_pkg::ACT_UP}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00000, 1'b1, '{1'b1, 5'd19, kes_pkg::ACT_UP}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00000, 1'b1, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		// zero intervals: repeat on every tick
		'{ROW_REG, kes_pkg::REG_HOLD_START,  8'h00, 20'h0, 1'b0, NO_EVENT},
		'{ROW_REG, kes_pkg::REG_HOLD_REPEAT, 8'h00, 20'h0, 1'b0, NO_EVENT},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00002, 1'b1, '{1'b1, 5'd1,  kes_pkg::ACT_DOWN}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00002, 1'b0, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00002, 1'b0, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		// full-scale intervals, then hold_start lowered below the count
		'{ROW_REG, kes_pkg::REG_HOLD_START,  8'hFF, 20'h0, 1'b0, NO_EVENT},
		'{ROW_REG, kes_pkg::REG_HOLD_REPEAT, 8'hFF, 20'h0, 1'b0, NO_EVENT},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00002, 1'b0, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00002, 1'b0, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		'{ROW_REG, kes_pkg::REG_HOLD_START,  8'h01, 20'h0, 1'b0, NO_EVENT},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00002, 1'b0, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		'{ROW_REG, kes_pkg::REG_HOLD_REPEAT, 8'h00, 20'h0, 1'b0, NO_EVENT},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00002, 1'b0, '{1'b0, 5'd0,  kes_pkg::ACT_NONE}},
		'{ROW_TICK, 2'd0, 8'd0, 20'hFFFFD, 1'b1, '{1'b1, 5'd0,  kes_pkg::ACT_DOWN}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00000, 1'b1, '{1'b1, 5'd0,  kes_pkg::ACT_UP}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00000, 1'b1, '{1'b1, 5'd1,  kes_pkg::ACT_UP}},
		// writes past the register list must not land anywhere
		'{ROW_REG, REG_SPARE_2,              8'hA5, 20'h0, 1'b0, NO_EVENT},
		'{ROW_REG, REG_SPARE_3,              8'h5A, 20'h0, 1'b0, NO_EVENT},
		'{ROW_REG, kes_pkg::REG_HOLD_START,  8'h02, 20'h0, 1'b0, NO_EVENT},
		'{ROW_REG, kes_pkg::REG_HOLD_REPEAT, 8'h01, 20'h0, 1'b0, NO_EVENT},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00001, 1'b1, '{1'b1, 5'd0,  kes_pkg::ACT_DOWN}},
		'{ROW_TICK, 2'd0, 8'd0, 20'h00000, 1'b1, '{1'b1, 5'd0,  kes_pkg::ACT_UP}}
	};

	// Random phases: sender idle and receiver stall, in percent
	int phase_send_idle  [4] = '{0, 54, 0, 33};
	int phase_recv_stall [4] = '{0, 0, 54, 33};

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            in_valid     = 1'b0;
	logic                            in_stall;
	logic [kes_pkg::IN_W-1:0]        pressed_mask = '0;
	logic                            out_valid;
	logic                            out_stall    = 1'b0;
	logic                            event_valid;
	logic [kes_pkg::BTN_W-1:0]       button;
	logic [1:0]                      action;
	logic                            cfg_we       = 1'b0;
	logic [kes_pkg::CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [kes_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

	// Predictor state and its copy of the registers
	logic [kes_pkg::NUM_BUTTONS-1:0] key_held        = '0;
	logic [kes_pkg::CNT_W-1:0]       hold_ticks      = '0;
	logic [kes_pkg::CNT_W-1:0]       repeat_ticks    = '0;
	logic [kes_pkg::CNT_W-1:0]       cfg_hold_start  = kes_pkg::HOLD_START_RST;
	logic [kes_pkg::CNT_W-1:0]       cfg_hold_repeat = kes_pkg::HOLD_REPEAT_RST;

	kes_pkg::kes_result_t            tick_expect_q [$];
	kes_pkg::kes_result_t            want;
	int                              send_idle_pct  = 0;
	int                              recv_stall_pct = 0;
	int                              error_count    = 0;
	int                              result_no      = 0;
	int                              quiet_cycles   = 0;

	keypad_event_scanner_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pressed_mask (pressed_mask),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_valid  (event_valid),
		.button       (button),
		.action       (action),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One scan tick: first closed or still-down key in index order decides
	function automatic kes_pkg::kes_result_t scan_tick(input logic [kes_pkg::IN_W-1:0] mask);
		kes_pkg::kes_result_t res;
		bit                   stop;
		res  = NO_EVENT;
		stop = 1'b0;
		for (int b = 0; b < kes_pkg::NUM_BUTTONS; b++) begin
			if (!stop) begin
				if (mask[b]) begin
					stop = 1'b1;
					if (!key_held[b]) begin
						key_held[b] = 1'b1;
						res = '{1'b1, kes_pkg::BTN_W'(b), kes_pkg::ACT_DOWN};
					end else if (hold_ticks >= cfg_hold_start) begin
						// clamp in case hold_start was lowered meanwhile
						hold_ticks = cfg_hold_start;
						if (repeat_ticks >= cfg_hold_repeat) begin
							repeat_ticks = '0;
							res = '{1'b1, kes_pkg::BTN_W'(b), kes_pkg::ACT_HOLD};
						end else begin
							repeat_ticks = repeat_ticks + 1'b1;
						end
					end else begin
						hold_ticks = hold_ticks + 1'b1;
					end
				end else if (key_held[b]) begin
					stop         = 1'b1;
					key_held[b]  = 1'b0;
					hold_ticks   = '0;
					repeat_ticks = '0;
					res = '{1'b1, kes_pkg::BTN_W'(b), kes_pkg::ACT_UP};
				end
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("%0t ns: result %0d %s: got %0d, expected %0d",
			$time, result_no, what, got, exp_val);
		error_count++;
	endtask

	// Offer one tick; returns at the edge of its transfer
	task automatic send_tick(input logic [kes_pkg::IN_W-1:0] mask, input bit typed,
			input kes_pkg::kes_result_t typed_res);
		kes_pkg::kes_result_t pred;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		pressed_mask <= mask;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = scan_tick(mask);
		tick_expect_q.push_back(typed ? typed_res : pred);
	endtask

	// Register write, only once the pipeline has drained
	task automatic write_reg(input logic [kes_pkg::CFG_IDX_W-1:0] sel,
			input logic [kes_pkg::CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		while (tick_expect_q.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
			kes_pkg::REG_HOLD_START:  cfg_hold_start  = val;
			kes_pkg::REG_HOLD_REPEAT: cfg_hold_repeat = val;
			default: ;
		endcase
	endtask

	// Receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (tick_expect_q.size() == 0) begin
				report_mismatch("with nothing pending, action", action, kes_pkg::ACT_NONE);
			end else begin
				want = tick_expect_q.pop_front();
				if (event_valid !== want.event_valid)
					report_mismatch("event_valid", event_valid, want.event_valid);
				if (button !== want.button)
					report_mismatch("button", button, want.button);
				if (action !== want.action)
					report_mismatch("action", action, want.action);
			end
			result_no++;
		end
	end

	// Watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [kes_pkg::IN_W-1:0] cur_mask;
		int                       pick;
		int                       flip;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		send_idle_pct  = 33;
		recv_stall_pct = 33;
		for (int r = 0; r < NUM_ROWS; r++) begin
			if (dir_rows[r].kind == ROW_REG)
				write_reg(dir_rows[r].reg_sel, dir_rows[r].reg_val);
			else
				send_tick(dir_rows[r].mask, dir_rows[r].typed, dir_rows[r].res);
		end

		// Random phases: contacts mostly held steady, some flips and noise
		cur_mask = '0;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = phase_send_idle[p];
			recv_stall_pct = phase_recv_stall[p];
			case (p)
				0: begin
					write_reg(kes_pkg::REG_HOLD_START, 8'd0);
					write_reg(kes_pkg::REG_HOLD_REPEAT, 8'd0);
				end
				1: begin
					write_reg(kes_pkg::REG_HOLD_START, 8'd3);
					write_reg(kes_pkg::REG_HOLD_REPEAT, 8'd2);
				end
				2: begin
					write_reg(kes_pkg::REG_HOLD_START, 8'd255);
					write_reg(kes_pkg::REG_HOLD_REPEAT, 8'd255);
				end
				default: begin
					write_reg(kes_pkg::REG_HOLD_START,
						kes_pkg::CFG_DATA_W'($urandom_range(0, 6)));
					write_reg(kes_pkg::REG_HOLD_REPEAT,
						kes_pkg::CFG_DATA_W'($urandom_range(0, 4)));
				end
			endcase
			for (int n = 0; n < PHASE_TICKS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					// keep the current contacts
				end else if (pick < 85) begin
					flip = $urandom_range(0, kes_pkg::IN_W - 1);
					cur_mask[flip] = ~cur_mask[flip];
				end else if (pick < 93) begin
					cur_mask = '0;
				end else begin
					cur_mask = kes_pkg::IN_W'($urandom);
				end
				send_tick(cur_mask, 1'b0, NO_EVENT);
			end
		end

		// Drain and finish
		in_valid <= 1'b0;
		while (tick_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
